[design/tlbp_pkg.sv]
package tlbp_pkg;

	// character codes
	localparam logic [7:0] SLASH_CHAR = 8'h2F;
	localparam logic [7:0] DIGIT_LOW  = 8'h30;
	localparam logic [7:0] DIGIT_HIGH = 8'h39;

	// slash counts: parsed levels run from four to eight, count saturates at nine
	localparam logic [3:0] FIRST_PARSED   = 4'd4;
	localparam logic [3:0] SLASHES_WANTED = 4'd8;
	localparam logic [3:0] SLASH_SAT      = 4'd9;

	localparam logic [11:0] MAX_LEVEL_VALUE = 12'd255;

	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 48;
	localparam int CAPTURED   = 4;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_COUNT = 2'd1,
		ST_BAD_LEVEL = 2'd2
	} tlbp_status_t;

	// one result word as it leaves the parser
	typedef struct packed {
		tlbp_status_t status;
		logic [7:0]   msg_type;
		logic [7:0]   ack_flag;
		logic [7:0]   command;
		logic [7:0]   sensor_id;
		logic [7:0]   node_id;
	} tlbp_result_t;

endpackage

[design/tlbp_in_stage.sv]
module tlbp_in_stage (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [tlbp_pkg::IN_DATA_W-1:0] s_tdata,  // [7:0] ch
	input  logic                          s_tlast,  // last
	input  logic                          go,
	output logic                          valid_s1,
	output logic [7:0]                    ch_s1,
	output logic                          last_s1
);
	import tlbp_pkg::*;

	// the stage frees up whenever the held word moves on
	assign s_tready = !valid_s1 || go;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			ch_s1   <= s_tdata[7:0];
			last_s1 <= s_tlast;
		end
	end

endmodule

[design/tlbp_parse.sv]
module tlbp_parse (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   go,
	input  logic [7:0]             ch,
	input  logic                   last,
	output tlbp_pkg::tlbp_result_t res
);
	import tlbp_pkg::*;

	logic [3:0]  slash_q;
	logic [7:0]  value_q;
	logic        nonempty_q;
	logic        bad_q;
	logic        any_bad_q;
	logic [7:0]  cap_q [CAPTURED];

	logic [3:0]  n_slash;
	logic [7:0]  n_value;
	logic        n_nonempty;
	logic        n_bad;
	logic        n_any_bad;
	logic [7:0]  n_cap [CAPTURED];
	logic        parsed;
	logic        is_digit;
	logic [3:0]  digit;
	logic [11:0] acc;

	assign parsed   = (slash_q >= FIRST_PARSED) && (slash_q <= SLASHES_WANTED);
	assign is_digit = (ch >= DIGIT_LOW) && (ch <= DIGIT_HIGH);
	assign digit    = 4'(ch - DIGIT_LOW);
	// value * 10 + digit
	assign acc = ({4'd0, value_q} << 3) + ({4'd0, value_q} << 1) + {8'd0, digit};

	// next state for one character
	always_comb begin
		n_slash    = slash_q;
		n_value    = value_q;
		n_nonempty = nonempty_q;
		n_bad      = bad_q;
		n_any_bad  = any_bad_q;
		n_cap      = cap_q;
		if (ch == SLASH_CHAR) begin
			if (parsed) begin
				if (bad_q || !nonempty_q) begin
					n_any_bad = 1'b1;
				end
				if (slash_q < SLASHES_WANTED) begin
					n_cap[slash_q[1:0]] = value_q;
				end
			end
			if (slash_q < SLASH_SAT) begin
				n_slash = slash_q + 4'd1;
			end
			n_value    = '0;
			n_nonempty = 1'b0;
			n_bad      = 1'b0;
		end else begin
			n_nonempty = 1'b1;
			if (parsed && !bad_q) begin
				if (!is_digit) begin
					n_bad = 1'b1;
				end else if (acc > MAX_LEVEL_VALUE) begin
					n_bad = 1'b1;
				end else begin
					n_value = acc[7:0];
				end
			end
		end
	end

	// result from the updated state
	always_comb begin
		res = '0;
		if (n_slash != SLASHES_WANTED) begin
			res.status = ST_BAD_COUNT;
		end else if (n_any_bad || n_bad || !n_nonempty) begin
			res.status = ST_BAD_LEVEL;
		end else begin
			res.status    = ST_OK;
			res.node_id   = n_cap[0];
			res.sensor_id = n_cap[1];
			res.command   = n_cap[2];
			res.ack_flag  = n_cap[3];
			res.msg_type  = n_value;
		end
	end

	// topic state, cleared after the final character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slash_q    <= '0;
			value_q    <= '0;
			nonempty_q <= 1'b0;
			bad_q      <= 1'b0;
			any_bad_q  <= 1'b0;
			for (int i = 0; i < CAPTURED; i++) begin
				cap_q[i] <= '0;
			end
		end else if (go) begin
			if (last) begin
				slash_q    <= '0;
				value_q    <= '0;
				nonempty_q <= 1'b0;
				bad_q      <= 1'b0;
				any_bad_q  <= 1'b0;
				for (int i = 0; i < CAPTURED; i++) begin
					cap_q[i] <= '0;
				end
			end else begin
				slash_q    <= n_slash;
				value_q    <= n_value;
				nonempty_q <= n_nonempty;
				bad_q      <= n_bad;
				any_bad_q  <= n_any_bad;
				cap_q      <= n_cap;
			end
		end
	end

endmodule

[design/tlbp_out_stage.sv]
module tlbp_out_stage (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           load,
	input  tlbp_pkg::tlbp_result_t         res,
	output logic                           free,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [tlbp_pkg::OUT_DATA_W-1:0] m_tdata
);
	import tlbp_pkg::*;

	tlbp_result_t res_q;

	assign free = !m_tvalid || m_tready;

	// zero padding above the status field
	assign m_tdata = {{(OUT_DATA_W - $bits(tlbp_result_t)){1'b0}}, res_q};

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (free) begin
			m_tvalid <= load;
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q <= res;
		end
	end

endmodule

[design/topic_level_byte_parser_top.sv]
// Topic level byte parser. Characters of a slash-separated topic enter on the
// s_ side, one word per cycle, with s_tlast on the final character; the block
// takes a character every cycle unless a final one waits. Levels four to eight
// (counted from zero, level k follows slash k) are parsed as decimal bytes. On
// the final character one result word leaves on the m_ side: node_id,
// sensor_id, command, ack_flag, msg_type and a status (0 ok, 1 slash count not
// eight, 2 bad numeric level); all five bytes are zero when status is not ok.
// A character passes an input register and then the parse logic into the
// output register, so a result word is valid in the cycle after its final
// character leaves the input register. Characters that are not final never
// wait in the input register. A final character waits in the input register
// only while the previous result is still held by the output register.
module topic_level_byte_parser_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [tlbp_pkg::IN_DATA_W-1:0]  s_tdata,  // [7:0] ch
	input  logic                            s_tlast,  // last
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [7:0] node_id, [15:8] sensor_id, [23:16] command, [31:24] ack_flag,
	// [39:32] msg_type, [41:40] status, [47:42] zero
	output logic [tlbp_pkg::OUT_DATA_W-1:0] m_tdata
);
	import tlbp_pkg::*;

	logic         valid_s1;
	logic [7:0]   ch_s1;
	logic         last_s1;
	logic         go;
	logic         out_free;
	tlbp_result_t res;

	// a final character needs room in the output register
	assign go = valid_s1 && (!last_s1 || out_free);

	tlbp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.go       (go),
		.valid_s1 (valid_s1),
		.ch_s1    (ch_s1),
		.last_s1  (last_s1)
	);

	tlbp_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.ch     (ch_s1),
		.last   (last_s1),
		.res    (res)
	);

	tlbp_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (go && last_s1),
		.res      (res),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

[design/tlbp_checker.sv]
module tlbp_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [tlbp_pkg::OUT_DATA_W-1:0] m_tdata
);
	import tlbp_pkg::*;

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// status is one of the three codes
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[41:40] != 2'b11)
		else $error("undefined status code");

	// an error result carries zero bytes
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[41:40] != ST_OK) |-> m_tdata[39:0] == 40'd0)
		else $error("error result with nonzero bytes");

	// padding stays zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[47:42] == 6'd0)
		else $error("nonzero padding in result word");

endmodule

bind topic_level_byte_parser_top tlbp_checker u_tlbp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
